// ===== design/pmst_pkg.sv =====
// pmst_pkg: shared constants, codes and state type for the prim spanning tree block
// no dependencies
`default_nettype none

package pmst_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int REQ_W    = 2;
    localparam int VIDX_W   = 6;
    localparam int WIN_W    = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 7;
    localparam int VC_RESET = 2;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BUILD = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SAME       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_WEIGHT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TREE_EDGE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SUMMARY    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_START  = 3'd6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET2,
        S_WALK,
        S_DRAIN
    } state_t;

endpackage

`default_nettype wire

// ===== design/pmst_matrix.sv =====
// pmst_matrix: weight matrix memory, one write port and one registered read port
// no dependencies
`default_nettype none

module pmst_matrix #(
    parameter int AW = 12,
    parameter int DW = 17
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [1 << AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/pmst_cell.sv =====
// pmst_cell: one vertex of the prim chain, holds lowcost, nearest and in-tree
// no dependencies; running minimum is handed to the next cell each cycle
`default_nettype none

module pmst_cell #(
    parameter int VW  = 6,
    parameter int LW  = 17,
    parameter int IDX = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          init,
    input  wire logic [VW-1:0] cur_v,
    input  wire logic [LW-1:0] rdata,
    input  wire logic          tok_in,
    input  wire logic [LW-1:0] best_in,
    input  wire logic [VW-1:0] idx_in,
    input  wire logic [VW-1:0] near_in,
    output logic               tok_out,
    output logic      [LW-1:0] best_out,
    output logic      [VW-1:0] idx_out,
    output logic      [VW-1:0] near_out
);

    logic          in_tree_reg, in_tree_next;
    logic [LW-1:0] low_reg, low_next;
    logic [VW-1:0] near_reg, near_next;
    logic          self;

    assign self = (cur_v == VW'(IDX));

    always_comb
    begin
        in_tree_next = in_tree_reg;
        low_next     = low_reg;
        near_next    = near_reg;
        if (init)
        begin
            in_tree_next = self;
            low_next     = self ? '0 : rdata;
            near_next    = cur_v;
        end
        else if (self)
        begin
            in_tree_next = 1'b1;
        end
        else if (!in_tree_reg && rdata < low_reg)
        begin
            low_next  = rdata;
            near_next = cur_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in)
        begin
            in_tree_reg <= in_tree_next;
            low_reg     <= low_next;
            near_reg    <= near_next;
        end
        if (tok_in && !in_tree_next && low_next < best_in)
        begin
            best_out <= low_next;
            idx_out  <= VW'(IDX);
            near_out <= near_next;
        end
        else
        begin
            best_out <= best_in;
            idx_out  <= idx_in;
            near_out <= near_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out <= 1'b0;
        end
        else
        begin
            tok_out <= tok_in;
        end
    end

endmodule

`default_nettype wire

// ===== design/prim_minimum_spanning_tree.sv =====
// prim_minimum_spanning_tree: top level, request sequencer, matrix and cell chain
// depends on pmst_pkg, pmst_matrix, pmst_cell
// clear: writes no-edge to every matrix entry; set edge: writes both (a,b) and (b,a), one edge at a time
// build: each tree step reads one matrix row through the cell chain, then drains the chain
// reset sweeps the matrix to no-edge and holds busy meanwhile; receiver cannot stall
`default_nettype none

module prim_minimum_spanning_tree
    import pmst_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [REQ_W-1:0]    req_type,
    input  wire logic [VIDX_W-1:0]   vertex_a,
    input  wire logic [VIDX_W-1:0]   vertex_b,
    input  wire logic [WIN_W-1:0]    weight,
    input  wire logic [VIDX_W-1:0]   start_vertex,
    input  wire logic                cfg_we,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    output logic                     valid,
    output logic      [STATUS_W-1:0] status,
    output logic      [VIDX_W-1:0]   edge_from,
    output logic      [VIDX_W-1:0]   edge_to,
    output logic      [WIN_W-1:0]    edge_weight,
    output logic      [VIDX_W-1:0]   edge_count,
    output logic                     connected,
    output logic                     last
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = 2 * VW;
    localparam int LW = WEIGHT_BITS + 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam logic [LW-1:0] NO_EDGE = LW'(1) << WEIGHT_BITS;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       vc_reg;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic                   clr_report_reg, clr_report_next;
    logic [VW-1:0]          sa_reg, sa_next;
    logic [VW-1:0]          sb_reg, sb_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [VW-1:0]          s_reg, s_next;
    logic [VW-1:0]          cur_v_reg, cur_v_next;
    logic                   init_reg, init_next;
    logic [VW-1:0]          k_reg, k_next;
    logic                   first_reg, first_next;
    logic [VW-1:0]          count_reg, count_next;

    logic                valid_reg, valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VIDX_W-1:0]   from_reg, from_next;
    logic [VIDX_W-1:0]   to_reg, to_next;
    logic [WIN_W-1:0]    ew_reg, ew_next;
    logic [VIDX_W-1:0]   ec_reg, ec_next;
    logic                conn_reg, conn_next;
    logic                last_reg, last_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [LW-1:0] mem_rdata;

    logic [NW-1:0] n_cl;
    int            n_int;

    logic          tok_l  [MAX_VERTICES + 1];
    logic [LW-1:0] best_l [MAX_VERTICES + 1];
    logic [VW-1:0] idx_l  [MAX_VERTICES + 1];
    logic [VW-1:0] near_l [MAX_VERTICES + 1];

    always_comb
    begin
        if (int'(vc_reg) < 2)
        begin
            n_int = 2;
        end
        else if (int'(vc_reg) > MAX_VERTICES)
        begin
            n_int = MAX_VERTICES;
        end
        else
        begin
            n_int = int'(vc_reg);
        end
    end

    assign n_cl = NW'(n_int);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= CFG_W'(VC_RESET);
        end
        else if (cfg_we)
        begin
            vc_reg <= cfg_wdata;
        end
    end

    pmst_matrix #(
        .AW (AW),
        .DW (LW)
    ) u_matrix (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mem_raddr   = {cur_v_reg, k_reg};
    assign tok_l[0]    = first_reg;
    assign best_l[0]   = NO_EDGE;
    assign idx_l[0]    = '0;
    assign near_l[0]   = '0;

    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        pmst_cell #(
            .VW  (VW),
            .LW  (LW),
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .init     (init_reg),
            .cur_v    (cur_v_reg),
            .rdata    (mem_rdata),
            .tok_in   (tok_l[i]),
            .best_in  (best_l[i]),
            .idx_in   (idx_l[i]),
            .near_in  (near_l[i]),
            .tok_out  (tok_l[i + 1]),
            .best_out (best_l[i + 1]),
            .idx_out  (idx_l[i + 1]),
            .near_out (near_l[i + 1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            first_reg      <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            first_reg      <= first_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        w_reg      <= w_next;
        s_reg      <= s_next;
        cur_v_reg  <= cur_v_next;
        init_reg   <= init_next;
        k_reg      <= k_next;
        count_reg  <= count_next;
        status_reg <= status_next;
        from_reg   <= from_next;
        to_reg     <= to_next;
        ew_reg     <= ew_next;
        ec_reg     <= ec_next;
        conn_reg   <= conn_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        sa_next         = sa_reg;
        sb_next         = sb_reg;
        w_next          = w_reg;
        s_next          = s_reg;
        cur_v_next      = cur_v_reg;
        init_next       = init_reg;
        k_next          = k_reg;
        first_next      = 1'b0;
        count_next      = count_reg;
        valid_next      = 1'b0;
        status_next     = ST_OK;
        from_next       = '0;
        to_next         = '0;
        ew_next         = '0;
        ec_next         = '0;
        conn_next       = 1'b0;
        last_next       = 1'b1;
        mem_we          = 1'b0;
        mem_waddr       = {sb_reg, sa_reg};
        mem_wdata       = LW'(w_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = NO_EDGE;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    valid_next = clr_report_reg;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        REQ_EDGE:
                        begin
                            if (weight == '0 || 32'(weight) >= (32'd1 << WEIGHT_BITS))
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_BAD_WEIGHT;
                            end
                            else if (vertex_a == vertex_b)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_SAME;
                            end
                            else if (int'(vertex_a) >= n_int || int'(vertex_b) >= n_int)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_BAD_VERTEX;
                            end
                            else
                            begin
                                sa_next    = VW'(vertex_a);
                                sb_next    = VW'(vertex_b);
                                w_next     = WEIGHT_BITS'(weight);
                                mem_we     = 1'b1;
                                mem_waddr  = {VW'(vertex_a), VW'(vertex_b)};
                                mem_wdata  = LW'(weight);
                                state_next = S_SET2;
                            end
                        end
                        REQ_BUILD:
                        begin
                            if (int'(start_vertex) >= n_int)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_BAD_START;
                            end
                            else
                            begin
                                s_next     = VW'(start_vertex);
                                cur_v_next = VW'(start_vertex);
                                init_next  = 1'b1;
                                k_next     = '0;
                                count_next = '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SET2:
            begin
                mem_we     = 1'b1;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                first_next = (k_reg == '0);
                k_next     = k_reg + VW'(1);
                if (k_reg == VW'(n_int - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (tok_l[n_cl])
                begin
                    valid_next = 1'b1;
                    k_next     = '0;
                    if (best_l[n_cl] < NO_EDGE)
                    begin
                        status_next = ST_TREE_EDGE;
                        from_next   = VIDX_W'(near_l[n_cl]);
                        to_next     = VIDX_W'(idx_l[n_cl]);
                        ew_next     = WIN_W'(best_l[n_cl]);
                        last_next   = 1'b0;
                        count_next  = count_reg + VW'(1);
                        cur_v_next  = idx_l[n_cl];
                        init_next   = 1'b0;
                        state_next  = S_WALK;
                    end
                    else
                    begin
                        status_next = ST_SUMMARY;
                        ec_next     = VIDX_W'(count_reg);
                        conn_next   = (int'(count_reg) + 1 == n_int);
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign valid       = valid_reg;
    assign status      = status_reg;
    assign edge_from   = from_reg;
    assign edge_to     = to_reg;
    assign edge_weight = ew_reg;
    assign edge_count  = ec_reg;
    assign connected   = conn_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for prim_minimum_spanning_tree
// drives clear, set-edge and build requests, predicts every result word and compares
// depends on pmst_pkg and the design sources
`default_nettype none

module tb_top;
    import pmst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = MAX_VERTICES_DEF;
    localparam logic [16:0] NO_EDGE = 17'h10000;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VIDX_W-1:0]   from;
        logic [VIDX_W-1:0]   to;
        logic [WIN_W-1:0]    wt;
        logic [VIDX_W-1:0]   count;
        logic                conn;
        logic                last;
    } result_t;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [VIDX_W-1:0] a;
        logic [VIDX_W-1:0] b;
        logic [WIN_W-1:0]  w;
        logic [VIDX_W-1:0] s;
        logic              has_exp;
        logic [STATUS_W-1:0] exp_status;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [REQ_W-1:0] req_type = '0;
    logic [VIDX_W-1:0] vertex_a = '0, vertex_b = '0, start_vertex = '0;
    logic [WIN_W-1:0] weight = '0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic valid;
    logic [STATUS_W-1:0] status;
    logic [VIDX_W-1:0] edge_from, edge_to, edge_count;
    logic [WIN_W-1:0] edge_weight;
    logic connected, last;

    prim_minimum_spanning_tree dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .vertex_a(vertex_a), .vertex_b(vertex_b),
        .weight(weight), .start_vertex(start_vertex),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .valid(valid), .status(status), .edge_from(edge_from), .edge_to(edge_to),
        .edge_weight(edge_weight), .edge_count(edge_count),
        .connected(connected), .last(last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    logic [16:0] graph [NV*NV];
    logic [6:0] vcount;
    result_t expected_words [$];
    int errors = 0;
    int idle_pct = 0;
    int quiet_cycles = 0;
    logic accepted_any;

    function automatic int active_n();
        if (vcount < 2) return 2;
        if (vcount > NV) return NV;
        return int'(vcount);
    endfunction

    function automatic result_t word(logic [STATUS_W-1:0] st);
        result_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict(row_t it);
        int n, cnt, v;
        logic [16:0] lc [NV];
        logic [5:0] near [NV];
        logic tree [NV];
        logic [16:0] best;
        result_t r;
        n = active_n();
        case (it.req)
            REQ_CLEAR:
            begin
                foreach (graph[i]) graph[i] = NO_EDGE;
                expected_words.push_back(word(ST_OK));
            end
            REQ_EDGE:
            begin
                if (it.w == 0) expected_words.push_back(word(ST_BAD_WEIGHT));
                else if (it.a == it.b) expected_words.push_back(word(ST_SAME));
                else if (it.a >= n || it.b >= n) expected_words.push_back(word(ST_BAD_VERTEX));
                else
                begin
                    graph[it.a*NV+it.b] = {1'b0, it.w};
                    graph[it.b*NV+it.a] = {1'b0, it.w};
                    expected_words.push_back(word(ST_OK));
                end
            end
            REQ_BUILD:
            begin
                if (it.s >= n)
                begin
                    expected_words.push_back(word(ST_BAD_START));
                    return;
                end
                for (int i = 0; i < n; i++)
                begin
                    tree[i] = 1'b0;
                    lc[i] = graph[it.s*NV+i];
                    near[i] = it.s;
                end
                lc[it.s] = '0;
                tree[it.s] = 1'b1;
                cnt = 0;
                for (int stp = 1; stp < n; stp++)
                begin
                    best = NO_EDGE;
                    v = it.s;
                    for (int i = 0; i < n; i++)
                        if (!tree[i] && lc[i] < best)
                        begin
                            best = lc[i];
                            v = i;
                        end
                    if (v == it.s) continue;
                    r = '0;
                    r.status = ST_TREE_EDGE;
                    r.from = near[v];
                    r.to = VIDX_W'(v);
                    r.wt = best[15:0];
                    expected_words.push_back(r);
                    cnt++;
                    tree[v] = 1'b1;
                    for (int k = 0; k < n; k++)
                        if (!tree[k] && graph[v*NV+k] < lc[k])
                        begin
                            lc[k] = graph[v*NV+k];
                            near[k] = VIDX_W'(v);
                        end
                end
                r = word(ST_SUMMARY);
                r.count = VIDX_W'(cnt);
                r.conn = (cnt + 1 == n);
                expected_words.push_back(r);
            end
            default: ;
        endcase
    endtask

    // result monitor
    always @(posedge clk)
    begin
        result_t got, exp_w;
        if (rst_n && valid)
        begin
            got = '{status, edge_from, edge_to, edge_weight, edge_count, connected, last};
            if (expected_words.size() == 0)
            begin
                $error("unexpected word status=%0d", status);
                errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (got.status != exp_w.status)
                begin
                    $error("status exp %0d got %0d", exp_w.status, got.status);
                    errors++;
                end
                if (got.from != exp_w.from)
                begin
                    $error("edge_from exp %0d got %0d", exp_w.from, got.from);
                    errors++;
                end
                if (got.to != exp_w.to)
                begin
                    $error("edge_to exp %0d got %0d", exp_w.to, got.to);
                    errors++;
                end
                if (got.wt != exp_w.wt)
                begin
                    $error("edge_weight exp %0d got %0d", exp_w.wt, got.wt);
                    errors++;
                end
                if (got.count != exp_w.count)
                begin
                    $error("edge_count exp %0d got %0d", exp_w.count, got.count);
                    errors++;
                end
                if (got.conn != exp_w.conn)
                begin
                    $error("connected exp %0d got %0d", exp_w.conn, got.conn);
                    errors++;
                end
                if (got.last != exp_w.last)
                begin
                    $error("last exp %0d got %0d", exp_w.last, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge clk)
    begin
        accepted_any = (start && !busy) || valid || cfg_we;
        quiet_cycles = accepted_any ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(row_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= it.req;
        vertex_a <= it.a;
        vertex_b <= it.b;
        weight <= it.w;
        start_vertex <= it.s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict(it);
        if (it.has_exp && expected_words.size() > 0
            && expected_words[expected_words.size()-1].status != it.exp_status)
        begin
            $error("status exp %0d got %0d from table", it.exp_status,
                   expected_words[expected_words.size()-1].status);
            errors++;
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (NV + 8) @(posedge clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        vcount = value;
    endtask

    function automatic row_t mk(logic [REQ_W-1:0] rq, int a, int b, int w, int s,
                                logic he = 1'b0, logic [STATUS_W-1:0] es = ST_OK);
        row_t r;
        r = '{rq, VIDX_W'(a), VIDX_W'(b), WIN_W'(w), VIDX_W'(s), he, es};
        return r;
    endfunction

    function automatic row_t rand_edge(int n);
        int p;
        p = $urandom_range(99);
        if (p < 85)
            return mk(REQ_EDGE, $urandom_range(n-1), $urandom_range(n-1),
                      ($urandom_range(3) == 0) ? $urandom_range(65535,1) : $urandom_range(20,1),
                      0);
        return mk(REQ_EDGE, $urandom_range(63), $urandom_range(63),
                  ($urandom_range(3) == 0) ? 0 : $urandom, $urandom_range(63));
    endfunction

    row_t directed [$];
    int n;

    initial
    begin
        foreach (graph[i]) graph[i] = NO_EDGE;
        vcount = CFG_W'(VC_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed table
        write_count(7'd0);
        directed = '{
            mk(REQ_BUILD, 0, 0, 0, 0),
            mk(REQ_EDGE, 0, 1, 0, 0, 1'b1, ST_BAD_WEIGHT),
            mk(REQ_EDGE, 63, 63, 5, 0, 1'b1, ST_SAME),
            mk(REQ_EDGE, 0, 63, 5, 0, 1'b1, ST_BAD_VERTEX),
            mk(REQ_EDGE, 1, 0, 16'hffff, 0, 1'b1, ST_OK),
            mk(REQ_BUILD, 0, 0, 0, 1),
            mk(REQ_BUILD, 0, 0, 0, 2, 1'b1, ST_BAD_START),
            mk(REQ_NONE, 63, 63, 16'hffff, 63),
            mk(REQ_CLEAR, 0, 0, 0, 0, 1'b1, ST_OK)
        };
        foreach (directed[i]) send(directed[i]);
        write_count(7'd127);
        directed = '{
            mk(REQ_EDGE, 63, 62, 1, 0, 1'b1, ST_OK),
            mk(REQ_EDGE, 0, 1, 3, 0, 1'b1, ST_OK),
            mk(REQ_EDGE, 0, 2, 3, 0, 1'b1, ST_OK),
            mk(REQ_EDGE, 1, 2, 1, 0, 1'b1, ST_OK),
            mk(REQ_EDGE, 2, 63, 3, 0, 1'b1, ST_OK),
            mk(REQ_EDGE, 0, 1, 2, 0, 1'b1, ST_OK),
            mk(REQ_BUILD, 0, 0, 0, 63),
            mk(REQ_BUILD, 0, 0, 0, 0),
            mk(REQ_EDGE, 21, 42, 16'h2a55, 0, 1'b1, ST_OK),
            mk(REQ_BUILD, 0, 0, 0, 42)
        };
        foreach (directed[i]) send(directed[i]);
        write_count(7'd3);
        send(mk(REQ_BUILD, 0, 0, 0, 2));

        // random phases: sender idles sometimes, then sender mostly idle, then no gaps
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 25 : (ph == 1) ? 87 : 0;
            for (int g = 0; g < 4; g++)
            begin
                case ($urandom_range(3))
                    0: write_count(CFG_W'($urandom_range(5, 2)));
                    1: write_count(CFG_W'($urandom_range(12, 6)));
                    2: write_count(CFG_W'($urandom_range(127)));
                    default: write_count(7'd64);
                endcase
                n = active_n();
                if ($urandom_range(1)) send(mk(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
                for (int e = 0; e < 15; e++) send(rand_edge(n));
                if ($urandom_range(7) == 0) send(mk(REQ_NONE, $urandom, $urandom, $urandom, $urandom));
                send(mk(REQ_BUILD, $urandom, $urandom, $urandom,
                        ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(n-1)));
                send(mk(REQ_BUILD, 0, 0, 0, $urandom_range(n-1)));
            end
        end

        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

`default_nettype wire
